>>> src/cst_pkg.sv
package cst_pkg;

    localparam int HOLD_DEPTH_DEF = 16;

    // result kinds
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    // input item codes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_DELIMITER  = 3'd0;
    localparam logic [2:0] CFG_QUOTE      = 3'd1;
    localparam logic [2:0] CFG_TRIM       = 3'd2;
    localparam logic [2:0] CFG_SKIP_EMPTY = 3'd3;
    localparam logic [2:0] CFG_FIRST_LINE = 3'd4;
    localparam logic [2:0] CFG_LAST_LINE  = 3'd5;

    // register reset values
    localparam logic [7:0]  RST_DELIMITER  = 8'h2C;
    localparam logic [7:0]  RST_QUOTE      = 8'h22;
    localparam logic [31:0] RST_FIRST_LINE = 32'd1;
    localparam logic [31:0] RST_LAST_LINE  = 32'd0;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // tab, lf, vt, ff, cr, space
    localparam logic [63:0] WS_MASK = 64'h0000_0001_0000_3E00;

    // hold buffer commands from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
        logic drop;
        logic clear;
    } t_hold_cmd;

    function automatic logic is_space(input logic [7:0] c);
        logic r;
        r = (c[7:6] == 2'b00) && WS_MASK[c[5:0]];
        return r;
    endfunction

endpackage

>>> src/cst_hold.sv
module cst_hold #(
    parameter int HOLD_DEPTH = cst_pkg::HOLD_DEPTH_DEF,
    localparam int CW = $clog2(HOLD_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cst_pkg::t_hold_cmd i_cmd,
    input  logic [7:0]         i_byte,
    output logic [CW-1:0]      o_count,
    output logic [7:0]         o_head,
    output logic               o_last_cr
);
    import cst_pkg::*;

    localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    logic [7:0]    r_buf [HOLD_DEPTH];
    logic [CW-1:0] r_count;
    logic          r_last_cr;

    // oldest byte always sits at entry 0, pop shifts the line down
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end else if (i_cmd.push) begin
            r_buf[r_count[IW-1:0]] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_last_cr <= 1'b0;
        end else begin
            priority if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.pop || i_cmd.drop) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.push) begin
                r_count   <= r_count + CW'(1);
                r_last_cr <= (i_byte == CH_CR);
            end else begin
                r_count <= r_count;
            end
        end
    end

    assign o_count   = r_count;
    assign o_head    = r_buf[0];
    assign o_last_cr = r_last_cr;

endmodule

>>> src/csv_stream_tokenizer_top.sv
// csv tokenizer: takes one stream byte per input transfer (op 0) or an end-of-input
// flush (op 1) and returns field bytes, field-end marks and row-end marks, one result
// per output transfer, with last set on the final result of each input item. a small
// sequencer decodes the item, then walks its results out through a single output
// register; the input stalls while an item is in work. an item that ends a line goes
// through the line counter increment and the line-range compare before its results
// go out. an item has at most HOLD_DEPTH + 1 results; whitespace held for trimming
// comes out in bursts. configuration writes are taken at any time but belong to idle
// periods; writing the trim register discards held whitespace.
module csv_stream_tokenizer_top #(
    parameter int HOLD_DEPTH = cst_pkg::HOLD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [7:0]  i_in_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_line_number,
    output logic        o_last,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import cst_pkg::*;

    localparam int CW = $clog2(HOLD_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LINE_INC,
        S_LINE_CMP,
        S_EMIT
    } t_state;

    // normal, inside quotes, quote seen inside quotes, after the closing quote
    typedef enum logic [1:0] {
        M_NORMAL,
        M_QUOTED,
        M_PENDING,
        M_CLOSED
    } t_mode;

    t_state r_state, n_state;

    // configuration
    logic [7:0]  r_delim, n_delim;
    logic [7:0]  r_quote, n_quote;
    logic        r_trim, n_trim;
    logic        r_skip, n_skip;
    logic [31:0] r_first_line, n_first_line;
    logic [31:0] r_last_line, n_last_line;

    // captured item
    logic        r_op, n_op;
    logic [7:0]  r_c, n_c;

    // parser state
    t_mode       r_mode, n_mode;
    logic        r_raw, n_raw;
    logic        r_data, n_data;
    logic        r_rowf, n_rowf;
    logic [31:0] r_line, n_line;
    logic [31:0] r_line_inc, n_line_inc;

    // result plan, walked out during emit
    logic [CW-1:0] r_flush_left, n_flush_left;
    logic        r_ovf, n_ovf;
    logic        r_byte_pend, n_byte_pend;
    logic        r_fend_pend, n_fend_pend;
    logic        r_rend_pend, n_rend_pend;
    // actions applied once all results are out
    logic        r_push, n_push;
    logic        r_fend, n_fend;
    logic        r_rend, n_rend;
    logic        r_clear, n_clear;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_out_byte, n_out_byte;
    logic [31:0] r_line_out, n_line_out;
    logic        r_last, n_last;

    // hold buffer
    t_hold_cmd   hold_cmd;
    logic [CW-1:0] hold_count;
    logic [7:0]  hold_head;
    logic        hold_last_cr;

    // decode results
    logic        d_drop, d_flush, d_ovf, d_push, d_byte, d_fend, d_fend_emit;
    logic        d_rend, d_clear;
    t_mode       d_mode;
    logic        d_raw, d_data, d_rowf;
    logic [CW-1:0] d_flush_n;

    logic        slot_free;
    logic        pending;
    logic        cfg_we;

    cst_hold #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_hold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (hold_cmd),
        .i_byte    (r_c),
        .o_count   (hold_count),
        .o_head    (hold_head),
        .o_last_cr (hold_last_cr)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign slot_free   = !r_out_valid || !i_out_stall;

    // item decode: what to flush, emit and close for the captured item
    always_comb begin
        logic is_d, is_lf, is_q, is_cr, sp;
        logic dbyte, crhold, rowf_after;
        is_d   = (r_c == r_delim);
        is_lf  = (r_c == CH_LF);
        is_q   = (r_c == r_quote);
        is_cr  = (r_c == CH_CR);
        sp     = is_space(r_c);
        dbyte  = 1'b0;
        crhold = 1'b0;

        d_drop      = 1'b0;
        d_flush     = 1'b0;
        d_ovf       = 1'b0;
        d_push      = 1'b0;
        d_byte      = 1'b0;
        d_fend      = 1'b0;
        d_fend_emit = 1'b0;
        d_rend      = 1'b0;
        d_clear     = 1'b0;
        d_mode      = r_mode;
        d_raw       = r_raw;
        d_data      = r_data;
        d_rowf      = r_rowf;

        if (r_op == OP_FLUSH) begin
            if (r_mode != M_NORMAL) begin
                d_fend = 1'b1;
            end else if (r_raw) begin
                d_flush = !r_trim;
                d_fend  = 1'b1;
            end
            d_clear = 1'b1;
        end else begin
            unique case (r_mode)
                M_NORMAL: begin
                    priority if (is_d) begin
                        d_flush = !r_trim;
                        d_fend  = 1'b1;
                    end else if (is_lf) begin
                        if (!r_trim) begin
                            // cr directly before lf is dropped
                            d_drop  = (hold_count != '0) && hold_last_cr;
                            d_flush = 1'b1;
                        end
                        d_fend = 1'b1;
                        d_rend = 1'b1;
                    end else if (is_q && !r_raw) begin
                        d_raw  = 1'b1;
                        d_mode = M_QUOTED;
                    end else begin
                        d_raw  = 1'b1;
                        dbyte  = 1'b1;
                        crhold = 1'b1;
                    end
                end
                M_QUOTED: begin
                    if (is_q) begin
                        d_mode = M_PENDING;
                    end else begin
                        dbyte = 1'b1;
                    end
                end
                M_PENDING: begin
                    if (is_q) begin
                        // doubled quote
                        dbyte  = 1'b1;
                        d_mode = M_QUOTED;
                    end else begin
                        d_mode = M_CLOSED;
                        if (is_d) begin
                            d_fend = 1'b1;
                        end else if (is_lf) begin
                            d_fend = 1'b1;
                            d_rend = 1'b1;
                        end
                    end
                end
                M_CLOSED: begin
                    if (is_d) begin
                        d_fend = 1'b1;
                    end else if (is_lf) begin
                        d_fend = 1'b1;
                        d_rend = 1'b1;
                    end
                end
                default: begin
                    d_mode = M_NORMAL;
                end
            endcase
        end

        // data byte handling, trimmed or plain
        if (dbyte) begin
            if (r_trim) begin
                if (sp) begin
                    if (r_data) begin
                        d_push = 1'b1;
                        d_ovf  = (hold_count == CW'(HOLD_DEPTH));
                    end
                end else begin
                    d_flush = 1'b1;
                    d_byte  = 1'b1;
                end
            end else begin
                d_flush = 1'b1;
                if (crhold && is_cr) begin
                    d_push = 1'b1;
                end else begin
                    d_byte = 1'b1;
                end
            end
        end

        d_flush_n = d_flush ? (hold_count - CW'(d_drop)) : '0;
        if (d_flush_n != '0 || d_byte) begin
            d_data = 1'b1;
        end

        d_fend_emit = d_fend && (d_data || !r_skip);
        rowf_after  = r_rowf || d_fend_emit;
        if (r_op == OP_FLUSH) begin
            d_rend = rowf_after;
        end

        if (d_fend) begin
            d_raw  = 1'b0;
            d_data = 1'b0;
            d_mode = M_NORMAL;
        end
        d_rowf = d_rend ? 1'b0 : rowf_after;
        if (d_clear) begin
            d_mode = M_NORMAL;
            d_raw  = 1'b0;
            d_data = 1'b0;
            d_rowf = 1'b0;
        end
    end

    assign pending = (r_flush_left != '0) || r_ovf || r_byte_pend || r_fend_pend
                   || r_rend_pend;

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_delim      = r_delim;
        n_quote      = r_quote;
        n_trim       = r_trim;
        n_skip       = r_skip;
        n_first_line = r_first_line;
        n_last_line  = r_last_line;
        n_op         = r_op;
        n_c          = r_c;
        n_mode       = r_mode;
        n_raw        = r_raw;
        n_data       = r_data;
        n_rowf       = r_rowf;
        n_line       = r_line;
        n_line_inc   = r_line_inc;
        n_flush_left = r_flush_left;
        n_ovf        = r_ovf;
        n_byte_pend  = r_byte_pend;
        n_fend_pend  = r_fend_pend;
        n_rend_pend  = r_rend_pend;
        n_push       = r_push;
        n_fend       = r_fend;
        n_rend       = r_rend;
        n_clear      = r_clear;
        n_out_valid  = r_out_valid && i_out_stall;
        n_kind       = r_kind;
        n_out_byte   = r_out_byte;
        n_line_out   = r_line_out;
        n_last       = r_last;
        hold_cmd     = '0;

        if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_DELIMITER:  n_delim = i_cfg_data[7:0];
                CFG_QUOTE:      n_quote = i_cfg_data[7:0];
                CFG_TRIM: begin
                    n_trim         = i_cfg_data[0];
                    hold_cmd.clear = 1'b1;
                end
                CFG_SKIP_EMPTY: n_skip = i_cfg_data[0];
                CFG_FIRST_LINE: n_first_line = i_cfg_data;
                CFG_LAST_LINE:  n_last_line = i_cfg_data;
                default: begin
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_c     = i_in_byte;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_mode        = d_mode;
                n_raw         = d_raw;
                n_data        = d_data;
                n_rowf        = d_rowf;
                n_flush_left  = d_flush_n;
                n_ovf         = d_ovf;
                n_byte_pend   = d_byte;
                n_fend_pend   = d_fend_emit;
                n_rend_pend   = 1'b0;
                n_push        = d_push;
                n_fend        = d_fend;
                n_rend        = d_rend;
                n_clear       = d_clear;
                hold_cmd.drop = d_drop;
                n_state       = d_rend ? S_LINE_INC : S_EMIT;
            end
            S_LINE_INC: begin
                // saturating line counter
                n_line_inc = (&r_line) ? r_line : r_line + 32'd1;
                n_state    = S_LINE_CMP;
            end
            S_LINE_CMP: begin
                n_rend_pend = (r_line_inc >= r_first_line)
                           && ((r_last_line == '0) || (r_line_inc <= r_last_line));
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!pending) begin
                    // all results out: apply deferred updates
                    hold_cmd.push  = r_push;
                    hold_cmd.clear = r_fend || r_clear;
                    if (r_clear) begin
                        n_line = '0;
                    end else if (r_rend) begin
                        n_line = r_line_inc;
                    end
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = '0;
                    n_line_out  = r_line;
                    priority if (r_flush_left != '0) begin
                        n_kind       = KIND_DATA;
                        n_out_byte   = hold_head;
                        hold_cmd.pop = 1'b1;
                        n_flush_left = r_flush_left - CW'(1);
                        n_last       = (r_flush_left == CW'(1)) && !r_ovf && !r_byte_pend
                                    && !r_fend_pend && !r_rend_pend;
                    end else if (r_ovf) begin
                        // buffer full: oldest held byte goes out
                        n_kind       = KIND_DATA;
                        n_out_byte   = hold_head;
                        hold_cmd.pop = 1'b1;
                        n_ovf        = 1'b0;
                        n_last       = !r_byte_pend && !r_fend_pend && !r_rend_pend;
                    end else if (r_byte_pend) begin
                        n_kind      = KIND_DATA;
                        n_out_byte  = r_c;
                        n_byte_pend = 1'b0;
                        n_last      = !r_fend_pend && !r_rend_pend;
                    end else if (r_fend_pend) begin
                        n_kind      = KIND_FIELD_END;
                        n_fend_pend = 1'b0;
                        n_last      = !r_rend_pend;
                    end else begin
                        n_kind      = KIND_ROW_END;
                        n_line_out  = r_line_inc;
                        n_rend_pend = 1'b0;
                        n_last      = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_delim      <= RST_DELIMITER;
            r_quote      <= RST_QUOTE;
            r_trim       <= 1'b0;
            r_skip       <= 1'b0;
            r_first_line <= RST_FIRST_LINE;
            r_last_line  <= RST_LAST_LINE;
            r_mode       <= M_NORMAL;
            r_raw        <= 1'b0;
            r_data       <= 1'b0;
            r_rowf       <= 1'b0;
            r_line       <= '0;
            r_flush_left <= '0;
            r_ovf        <= 1'b0;
            r_byte_pend  <= 1'b0;
            r_fend_pend  <= 1'b0;
            r_rend_pend  <= 1'b0;
            r_push       <= 1'b0;
            r_fend       <= 1'b0;
            r_rend       <= 1'b0;
            r_clear      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_delim      <= n_delim;
            r_quote      <= n_quote;
            r_trim       <= n_trim;
            r_skip       <= n_skip;
            r_first_line <= n_first_line;
            r_last_line  <= n_last_line;
            r_mode       <= n_mode;
            r_raw        <= n_raw;
            r_data       <= n_data;
            r_rowf       <= n_rowf;
            r_line       <= n_line;
            r_flush_left <= n_flush_left;
            r_ovf        <= n_ovf;
            r_byte_pend  <= n_byte_pend;
            r_fend_pend  <= n_fend_pend;
            r_rend_pend  <= n_rend_pend;
            r_push       <= n_push;
            r_fend       <= n_fend;
            r_rend       <= n_rend;
            r_clear      <= n_clear;
            r_out_valid  <= n_out_valid;
        end
        // payload, no reset needed
        r_op       <= n_op;
        r_c        <= n_c;
        r_line_inc <= n_line_inc;
        r_kind     <= n_kind;
        r_out_byte <= n_out_byte;
        r_line_out <= n_line_out;
        r_last     <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_byte    = r_out_byte;
    assign o_line_number = r_line_out;
    assign o_last        = r_last;

endmodule

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam int HOLD_DEPTH    = HOLD_DEPTH_DEF;
    localparam int IDLE_LIMIT    = 2000;  // cycles without any transfer before giving up
    localparam int SETTLE_CYCLES = 32;    // covers the longest item in work with no result
    localparam int MAX_REPORTS   = 10;

    // parser position inside a field
    typedef enum logic [1:0] {
        PM_NORMAL,
        PM_QUOTED,
        PM_QUOTE_SEEN,
        PM_CLOSED
    } t_parse_mode;

    // one token leaving the tokenizer
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [31:0] line;
        logic        last_flag;
    } t_token;

    // dut ports, all inputs known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_op        = OP_DATA;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [31:0] o_line_number;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_DELIMITER;
    logic [31:0] i_cfg_data  = 32'd0;

    // tokenizer image: register copy
    logic [7:0]  cfg_delim;
    logic [7:0]  cfg_quote;
    logic        cfg_trim;
    logic        cfg_skip;
    logic [31:0] cfg_first;
    logic [31:0] cfg_last;

    // tokenizer image: parse state
    t_parse_mode pmode;
    logic [7:0]  held [HOLD_DEPTH];
    int          held_n;
    logic        f_raw;
    logic        f_data;
    logic        row_fields;
    logic [31:0] line_cnt;

    t_token step_tokens[$];   // tokens of the item being predicted
    t_token token_q[$];       // tokens still owed by the dut

    int n_errors    = 0;
    int n_items     = 0;
    int idle_cycles = 0;
    bit sender_steady = 1'b0; // no gaps between input transfers while set

    always #5 i_clk = ~i_clk;

    csv_stream_tokenizer_top #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_line_number (o_line_number),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // token prediction
    // ------------------------------------------------------------------

    // tab, lf, vt, ff, cr, space
    function automatic logic is_blank(input logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] b);
        t_token t;
        t.kind      = kind;
        t.data      = b;
        t.line      = line_cnt;
        t.last_flag = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void release_held();
        for (int i = 0; i < held_n; i++) emit(KIND_DATA, held[i]);
        if (held_n > 0) f_data = 1'b1;
        held_n = 0;
    endfunction

    // a full buffer gives up its oldest byte as data
    function automatic void hold_byte(input logic [7:0] c);
        if (held_n >= HOLD_DEPTH) begin
            emit(KIND_DATA, held[0]);
            for (int i = 1; i < HOLD_DEPTH; i++) held[i-1] = held[i];
            held_n = HOLD_DEPTH - 1;
        end
        held[held_n] = c;
        held_n++;
    endfunction

    function automatic void field_byte(input logic [7:0] c, input logic cr_may_hold);
        if (cfg_trim) begin
            if (is_blank(c)) begin
                // leading blanks vanish, inner ones wait
                if (f_data) hold_byte(c);
            end else begin
                release_held();
                emit(KIND_DATA, c);
                f_data = 1'b1;
            end
        end else begin
            release_held();
            if (cr_may_hold && c == CH_CR) begin
                hold_byte(c);
            end else begin
                emit(KIND_DATA, c);
                f_data = 1'b1;
            end
        end
    endfunction

    function automatic void end_of_field();
        if (f_data || !cfg_skip) begin
            emit(KIND_FIELD_END, 8'h00);
            row_fields = 1'b1;
        end
        held_n = 0;
        f_raw  = 1'b0;
        f_data = 1'b0;
        pmode  = PM_NORMAL;
    endfunction

    function automatic void end_of_line();
        if (line_cnt != 32'hFFFF_FFFF) line_cnt++;
        if (line_cnt >= cfg_first && (cfg_last == 32'd0 || line_cnt <= cfg_last))
            emit(KIND_ROW_END, 8'h00);
        row_fields = 1'b0;
    endfunction

    // after a closing quote only a delimiter or lf matters
    function automatic void byte_after_close(input logic [7:0] c);
        if (c == cfg_delim) begin
            end_of_field();
        end else if (c == CH_LF) begin
            end_of_field();
            end_of_line();
        end
    endfunction

    // delimiter wins over lf, lf over quote
    function automatic void byte_unquoted(input logic [7:0] c);
        if (c == cfg_delim) begin
            if (!cfg_trim) release_held();
            end_of_field();
        end else if (c == CH_LF) begin
            if (!cfg_trim) begin
                // cr right before lf is dropped
                if (held_n > 0 && held[held_n-1] == CH_CR) held_n--;
                release_held();
            end
            end_of_field();
            end_of_line();
        end else if (c == cfg_quote && !f_raw) begin
            f_raw = 1'b1;
            pmode = PM_QUOTED;
        end else begin
            f_raw = 1'b1;
            field_byte(c, 1'b1);
        end
    endfunction

    function automatic void clear_parse();
        pmode      = PM_NORMAL;
        held_n     = 0;
        f_raw      = 1'b0;
        f_data     = 1'b0;
        row_fields = 1'b0;
        line_cnt   = 32'd0;
    endfunction

    function automatic void apply_cfg(input logic [2:0] idx, input logic [31:0] d);
        case (idx)
            CFG_DELIMITER:  cfg_delim = d[7:0];
            CFG_QUOTE:      cfg_quote = d[7:0];
            CFG_TRIM: begin
                cfg_trim = d[0];
                held_n   = 0;
            end
            CFG_SKIP_EMPTY: cfg_skip  = d[0];
            CFG_FIRST_LINE: cfg_first = d;
            CFG_LAST_LINE:  cfg_last  = d;
            default: ;
        endcase
    endfunction

    function automatic void predict_item(input logic op, input logic [7:0] c);
        step_tokens.delete();
        if (op == OP_FLUSH) begin
            // close whatever field is open, then the row, then start over
            if (pmode != PM_NORMAL) begin
                end_of_field();
            end else if (f_raw) begin
                if (!cfg_trim) release_held();
                end_of_field();
            end
            if (row_fields) end_of_line();
            clear_parse();
        end else begin
            case (pmode)
                PM_NORMAL: byte_unquoted(c);
                PM_QUOTED: begin
                    if (c == cfg_quote) pmode = PM_QUOTE_SEEN;
                    else field_byte(c, 1'b0);
                end
                PM_QUOTE_SEEN: begin
                    if (c == cfg_quote) begin
                        // doubled quote stands for one
                        field_byte(c, 1'b0);
                        pmode = PM_QUOTED;
                    end else begin
                        pmode = PM_CLOSED;
                        byte_after_close(c);
                    end
                end
                default: byte_after_close(c);
            endcase
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_flag = 1'b1;
        foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // gap after a transfer: mostly none or short, a few long
    task automatic idle_sender();
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!sender_steady) begin
            if (r >= 94) gap = $urandom_range(8, 40);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] b);
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_item(op, b);
        n_items++;
        idle_sender();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(OP_DATA, s[i]);
    endtask

    // always waits for a clock edge so valid is never set twice in a step
    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (token_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_cfg(idx, d);
    endtask

    task automatic configure(input logic [7:0] d, input logic [7:0] q, input logic t,
                             input logic s, input logic [31:0] f, input logic [31:0] l);
        settle();
        cfg_write(CFG_DELIMITER, {24'd0, d});
        cfg_write(CFG_QUOTE, {24'd0, q});
        cfg_write(CFG_TRIM, {31'd0, t});
        cfg_write(CFG_SKIP_EMPTY, {31'd0, s});
        cfg_write(CFG_FIRST_LINE, f);
        cfg_write(CFG_LAST_LINE, l);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // random csv content
    // ------------------------------------------------------------------

    // any byte that is not special under the current registers
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
        else c = 8'($urandom_range(8'h61, 8'h7A));
        while (c == cfg_delim || c == CH_LF || c == cfg_quote) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        logic [7:0] c;
        c = CH_LF;
        while (c == CH_LF || c == cfg_delim || c == cfg_quote) begin
            case ($urandom_range(0, 4))
                0: c = 8'h09;
                1: c = 8'h0B;
                2: c = 8'h0C;
                3: c = CH_CR;
                default: c = 8'h20;
            endcase
        end
        return c;
    endfunction

    task automatic send_field();
        int sel;
        int n;
        int r;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            // plain field
            n = $urandom_range(0, 5);
            repeat (n) send_item(OP_DATA, plain_char());
        end else if (sel < 7) begin
            // quoted field with delimiters, lf and doubled quotes inside
            send_item(OP_DATA, cfg_quote);
            n = $urandom_range(0, 6);
            repeat (n) begin
                r = $urandom_range(0, 9);
                if (r < 6) begin
                    send_item(OP_DATA, plain_char());
                end else if (r == 6) begin
                    send_item(OP_DATA, cfg_delim);
                end else if (r == 7) begin
                    send_item(OP_DATA, CH_LF);
                end else if (r == 8) begin
                    send_item(OP_DATA, cfg_quote);
                    send_item(OP_DATA, cfg_quote);
                end else begin
                    send_item(OP_DATA, blank_char());
                end
            end
            send_item(OP_DATA, cfg_quote);
            // stray bytes after the closing quote
            if ($urandom_range(0, 4) == 0) send_item(OP_DATA, plain_char());
        end else if (sel < 9) begin
            // blank padding, sometimes long enough to overflow the hold buffer
            repeat ($urandom_range(0, 3)) send_item(OP_DATA, blank_char());
            repeat ($urandom_range(1, 3)) send_item(OP_DATA, plain_char());
            if ($urandom_range(0, 4) == 0) n = $urandom_range(14, 20);
            else n = $urandom_range(0, 3);
            repeat (n) send_item(OP_DATA, blank_char());
            if ($urandom_range(0, 1) == 0) send_item(OP_DATA, plain_char());
        end
        // otherwise an empty field
    endtask

    task automatic send_row();
        int nf;
        int r;
        sender_steady = ($urandom_range(0, 4) == 0);
        nf = $urandom_range(1, 4);
        for (int i = 0; i < nf; i++) begin
            if (i > 0) send_item(OP_DATA, cfg_delim);
            send_field();
        end
        r = $urandom_range(0, 19);
        if (r < 12) begin
            send_item(OP_DATA, CH_LF);
        end else if (r < 16) begin
            send_item(OP_DATA, CH_CR);
            send_item(OP_DATA, CH_LF);
        end else if (r < 18) begin
            send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
        end
        // else the row is left open and the next one runs into it
        sender_steady = 1'b0;
    endtask

    task automatic send_noise();
        logic op;
        repeat ($urandom_range(2, 8)) begin
            op = ($urandom_range(0, 15) == 0) ? OP_FLUSH : OP_DATA;
            send_item(op, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(input logic [7:0] d, input logic [7:0] q, input logic t,
                             input logic s, input logic [31:0] f, input logic [31:0] l,
                             input int n_target);
        int start;
        configure(d, q, t, s, f, l);
        start = n_items;
        while (n_items - start < n_target) begin
            if ($urandom_range(0, 7) == 0) send_noise();
            else send_row();
            // now and then let the dut drain completely
            if ($urandom_range(0, 24) == 0) wait_results();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset registers: quoting, doubled quote, junk after close, crlf, held cr at flush
    task automatic test_defaults();
        send_text("a,\"x\"\"\"z,\015\n");
        send_text("b\015");
        send_item(OP_FLUSH, 8'h00);
        // unterminated quote still gets its field end
        send_text("\"");
        send_item(OP_FLUSH, 8'hFF);
    endtask

    // trimming with empty fields skipped; a trim write drops held blanks
    task automatic test_trim_and_skip();
        configure(8'h2C, 8'h22, 1'b1, 1'b1, 32'd1, 32'd0);
        send_text(" a  ");
        configure(8'h2C, 8'h22, 1'b1, 1'b1, 32'd1, 32'd0);
        send_text("b,,\n");
    endtask

    // special byte priority and extreme byte values as specials
    task automatic test_special_bytes();
        configure(CH_LF, CH_LF, 1'b0, 1'b0, 32'd1, 32'd0);
        send_text("a\n");
        configure(8'h00, 8'hFF, 1'b0, 1'b0, 32'd1, 32'd0);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'h71);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, CH_LF);
    endtask

    // row marks only inside the line window, lf beating the quote byte
    task automatic test_line_window();
        configure(8'h2C, CH_LF, 1'b0, 1'b0, 32'd2, 32'd3);
        send_text("\n\n\n\n");
    endtask

    task automatic test_random_streams();
        run_phase(8'h2C, 8'h22, 1'b0, 1'b0, 32'd1, 32'd0, 50);
        run_phase(8'h2C, 8'h22, 1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF, 50);
        run_phase(8'hFF, 8'h00, 1'b0, 1'b1, 32'd3, 32'd6, 50);
        run_phase(8'h00, 8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0, 50);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  32'($urandom_range(0, 4)), 32'($urandom_range(0, 8)), 50);
        run_phase(8'h3B, 8'h27, 1'b1, 1'b0, 32'd1, 32'd0, 50);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        cfg_delim = RST_DELIMITER;
        cfg_quote = RST_QUOTE;
        cfg_trim  = 1'b0;
        cfg_skip  = 1'b0;
        cfg_first = RST_FIRST_LINE;
        cfg_last  = RST_LAST_LINE;
        clear_parse();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_trim_and_skip();
        test_special_bytes();
        test_line_window();
        test_random_streams();

        settle();
        if (n_errors == 0 && token_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // output side: random stall, short bursts mostly, some long, some free runs
    // ------------------------------------------------------------------

    int stall_left = 0;
    int free_left  = 0;

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left   = free_left - 1;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0) free_left = $urandom_range(30, 150);
            else free_left = $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(10, 40);
            else stall_left = $urandom_range(1, 3);
        end
    end

    // compare every output transfer with the oldest owed token
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected token: kind %0d byte %02h line %0d last %0b",
                             o_kind, o_out_byte, o_line_number, o_last);
            end else begin
                want = token_q.pop_front();
                if (o_kind !== want.kind || o_out_byte !== want.data ||
                    o_line_number !== want.line || o_last !== want.last_flag) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("token mismatch: expected kind %0d byte %02h line %0d last %0b,",
                                 want.kind, want.data, want.line, want.last_flag,
                                 " got kind %0d byte %02h line %0d last %0b",
                                 o_kind, o_out_byte, o_line_number, o_last);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

>>> csv_stream_tokenizer_top.f
src/cst_pkg.sv
src/cst_hold.sv
src/csv_stream_tokenizer_top.sv
test/testbench.sv
